[hdl/hsv2rgb_pkg.sv]
// ---------------------------------------------------------------------------
// hsv2rgb_pkg
// types, constants and the sector map for the hsv to rgb pixel converter
// ---------------------------------------------------------------------------
package hsv2rgb_pkg;

  // hue units in one 60 degree sector
  localparam logic [11:0] HUE_PER_SECTOR = 12'd3840;
  // sectors reachable by a 15-bit hue (0..8)
  localparam int unsigned NUM_SECTORS = 9;
  localparam int unsigned SECTOR_W = 4;

  // start of each sector in hue units
  localparam logic [14:0] SECTOR_BASE [NUM_SECTORS] = '{
    15'd0, 15'd3840, 15'd7680, 15'd11520, 15'd15360,
    15'd19200, 15'd23040, 15'd26880, 15'd30720
  };

  // what a channel carries on top of the offset m
  typedef enum logic [1:0] {
    SEL_Z,  // zero
    SEL_C,  // chroma
    SEL_X   // secondary term
  } chan_sel_t;

  typedef struct packed {
    chan_sel_t red;
    chan_sel_t green;
    chan_sel_t blue;
  } pix_sel_t;

  function automatic pix_sel_t sector_map(input logic [SECTOR_W-1:0] sector);
    pix_sel_t s;
    case (sector)
      4'd0:    s = '{red: SEL_C, green: SEL_X, blue: SEL_Z};
      4'd1:    s = '{red: SEL_X, green: SEL_C, blue: SEL_Z};
      4'd2:    s = '{red: SEL_Z, green: SEL_C, blue: SEL_X};
      4'd3:    s = '{red: SEL_Z, green: SEL_X, blue: SEL_C};
      4'd4:    s = '{red: SEL_X, green: SEL_Z, blue: SEL_C};
      default: s = '{red: SEL_C, green: SEL_Z, blue: SEL_X};
    endcase
    return s;
  endfunction

endpackage

[hdl/hsv_to_rgb_converter.sv]
// ---------------------------------------------------------------------------
// hsv_to_rgb_converter
// four-stage pipelined hsv to 8-bit rgb pixel converter
// ---------------------------------------------------------------------------
// One word in, one word out. Hue is in 1/64 degree (0..23039), saturation and
// brightness are Q1.15 with 32768 = 1.0. A word is taken on every clock edge
// at which start is high; busy is always low, so a new pixel can enter every
// cycle. The result sits on out_red/out_green/out_blue for exactly one
// cycle, flagged by out_valid; the receiver has no way to hold it off, so
// it must take it in that cycle. The four register stages, the first of
// which loads at the accepting edge, are: hue split and chroma multiply,
// the two chroma-by-weight multiplies, the per-channel subtract, and the
// final scale and clamp. Hue codes above 23039 land in sectors 6..8 and
// use the last sector's channel order. Inputs above 1.0 are handled
// exactly and each channel saturates to 0..255.
// ---------------------------------------------------------------------------
module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [14:0] in_hue,
  input  logic [15:0] in_saturation,
  input  logic [15:0] in_brightness,
  output logic        out_valid,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue
);

  // math: every channel is floor(n * 255 / (3840 * 2^30)) with
  //   n = v * 2^15 * 3840 - c * u, c = v * s
  // where u = 0 for the chroma channel, 3840 for the zero channel and
  // 3840 - t for the secondary channel (t the weight of x). since
  // 255 / 3840 = 17 / 256 the divide becomes (n * 17) >>> 38, exact.

  // ---------------- stage 1: sector split, chroma multiply ----------------
  logic                v1_r;
  logic [31:0]         c1_r, c1_nxt;
  logic [15:0]         val1_r;
  logic [11:0]         ux1_r, ux1_nxt;
  pix_sel_t            sel1_r, sel1_nxt;

  logic [SECTOR_W-1:0] sector;
  logic [14:0]         frac;

  always_comb begin
    sector = '0;
    for (int k = 1; k < NUM_SECTORS; k++) begin
      sector = sector + SECTOR_W'(in_hue >= SECTOR_BASE[k]);
    end
    frac     = in_hue - SECTOR_BASE[sector];
    // even sectors weight x by frac, odd by 3840 - frac; u is the complement
    ux1_nxt  = sector[0] ? frac[11:0] : (HUE_PER_SECTOR - frac[11:0]);
    sel1_nxt = sector_map(sector);
    c1_nxt   = 32'(in_brightness) * 32'(in_saturation);
  end

  // ---------------- stage 2: scale chroma and value ----------------
  logic                v2_r;
  logic [43:0]         cuc2_r, cux2_r;
  logic [42:0]         vbig2_r;
  pix_sel_t            sel2_r;

  // ---------------- stage 3: per-channel numerator ----------------
  logic                v3_r;
  logic signed [44:0]  n3_r [3];
  logic signed [44:0]  n3_nxt [3];
  pix_sel_t            sel3_r;

  function automatic logic [43:0] pick_u(input chan_sel_t s,
                                         input logic [43:0] cuc,
                                         input logic [43:0] cux);
    logic [43:0] r;
    case (s)
      SEL_C:   r = '0;    // chroma channel: c*u vanishes
      SEL_Z:   r = cuc;   // zero channel: full c*3840 taken off
      SEL_X:   r = cux;
      default: r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    n3_nxt[0] = $signed({2'b00, vbig2_r}) - $signed({1'b0, pick_u(sel2_r.red, cuc2_r, cux2_r)});
    n3_nxt[1] = $signed({2'b00, vbig2_r})
              - $signed({1'b0, pick_u(sel2_r.green, cuc2_r, cux2_r)});
    n3_nxt[2] = $signed({2'b00, vbig2_r}) - $signed({1'b0, pick_u(sel2_r.blue, cuc2_r, cux2_r)});
  end

  // ---------------- stage 4: scale by 17/2^38 and clamp ----------------
  logic               out_valid_r;
  logic [7:0]         chan_r [3];
  logic [7:0]         chan_nxt [3];

  function automatic logic [7:0] to_pixel(input logic signed [44:0] n);
    logic signed [49:0] p;
    logic [11:0]        q;
    logic [7:0]         r;
    p = $signed({{5{n[44]}}, n});
    p = (p <<< 4) + p;
    q = p[49:38];
    if (q[11]) begin
      r = 8'd0;           // negative offset saturates low
    end else if (q[10:8] != 3'd0) begin
      r = 8'd255;         // above full scale
    end else begin
      r = q[7:0];
    end
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      chan_nxt[i] = to_pixel(n3_r[i]);
    end
  end

  // ---------------- registers ----------------
  // valid bits reset; payload flops run free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= start;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    // stage 1
    c1_r    <= c1_nxt;
    val1_r  <= in_brightness;
    ux1_r   <= ux1_nxt;
    sel1_r  <= sel1_nxt;
    // stage 2
    cuc2_r  <= 44'(c1_r) * 44'(HUE_PER_SECTOR);
    cux2_r  <= 44'(c1_r) * 44'(ux1_r);
    vbig2_r <= {28'(val1_r) * 28'(HUE_PER_SECTOR), 15'd0};
    sel2_r  <= sel1_r;
    // stage 3
    n3_r    <= n3_nxt;
    sel3_r  <= sel2_r;
    // stage 4
    chan_r  <= chan_nxt;
  end

  // never stalls: one word per clock
  assign busy      = 1'b0;
  assign out_valid = out_valid_r;
  assign out_red   = chan_r[0];
  assign out_green = chan_r[1];
  assign out_blue  = chan_r[2];

  // ---------------- assertions ----------------
  // a result only leaves for a word that earlier entered stage 1
  a_valid_track: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(v1_r, 3))
    else $error("result strobe without matching pipeline entry");

  // every sector gives chroma to exactly one channel and zero to exactly one
  a_one_chroma: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> ($onehot({sel1_r.red == SEL_C, sel1_r.green == SEL_C, sel1_r.blue == SEL_C})
              && $onehot({sel1_r.red == SEL_Z, sel1_r.green == SEL_Z,
                          sel1_r.blue == SEL_Z})))
    else $error("sector map does not assign chroma and zero once each");

  // when red is the chroma channel, it carries the largest numerator
  a_chroma_max: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && sel3_r.red == SEL_C) |-> (n3_r[0] >= n3_r[1] && n3_r[0] >= n3_r[2]))
    else $error("chroma channel is not the brightest");

endmodule
